// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the counting table.
// Each macro expands to one labeled concurrent assertion on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define MCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every edge, also while reset is held.
`define MCT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mct_pkg.sv =====
// Package for the multiset counting table: codes, field widths, output layout
// and the sequencer state type. Used by the core and its checker.
package mct_pkg;

	localparam int ENTRIES_DEF  = 64;
	localparam int KEY_BITS_DEF = 32;

	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 31;
	localparam int DIST_W = 7;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

	// Result layout in m_tdata, lowest bits first.
	localparam int OUT_BITS   = STAT_W + CNT_W + DIST_W + CNT_W;
	localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_ST_LSB = 0;
	localparam int OUT_ST_MSB = OUT_ST_LSB + STAT_W - 1;
	localparam int OUT_KC_LSB = OUT_ST_MSB + 1;
	localparam int OUT_KC_MSB = OUT_KC_LSB + CNT_W - 1;
	localparam int OUT_DK_LSB = OUT_KC_MSB + 1;
	localparam int OUT_DK_MSB = OUT_DK_LSB + DIST_W - 1;
	localparam int OUT_TC_LSB = OUT_DK_MSB + 1;
	localparam int OUT_TC_MSB = OUT_TC_LSB + CNT_W - 1;

	typedef enum logic [1:0] {
		SM_IDLE,
		SM_SCAN,
		SM_DRAIN,
		SM_UPDATE
	} mct_state_t;

endpackage

// ===== hw/rtl/multiset_count_table_core.sv =====
// Top level of the multiset counting table: a scanning sequencer over a key
// and count memory, with valid flags in flip-flops. Depends on mct_pkg.
//
// Usage:
// Requests arrive on the s_tvalid/s_tready/s_tdata channel; each carries an
// opcode (insert, delete, query), a signed key and an amount. Every request
// yields exactly one result on m_tvalid/m_tready/m_tdata: a status, the key's
// count after the request, the number of distinct keys and the saturating
// total of all counts.
// A request is handled by one compare unit that walks the table, one entry
// per cycle through a registered memory read, then passes the drain state and
// commits in the update state, which registers m_tvalid. s_tready is high
// only while no request is in work, so a new request is taken only once the
// last one has left the update state.
// The result sits in an output register. While the receiver stalls, a new
// request can still be accepted and scanned; its commit waits until the
// output register is free, so nothing is lost or overwritten.
// Reset clears the valid flags, the distinct count and the total in one step;
// no clearing pass is needed and a request can be taken right after reset.
module multiset_count_table_core #(
	parameter int ENTRIES  = mct_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = mct_pkg::KEY_BITS_DEF,
	localparam int S_TDATA_W =
		((mct_pkg::OP_W + KEY_BITS + mct_pkg::CNT_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata fields, lowest bit first: opcode, key, amount, zero fill.
	input  logic [S_TDATA_W-1:0]          s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata fields, lowest bit first: status, key_count, distinct_keys,
	// total_count, zero fill.
	output logic [mct_pkg::M_TDATA_W-1:0] m_tdata
);
	import mct_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int DST_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [KEY_BITS-1:0] KEY_RESERVED = {1'b1, {(KEY_BITS-1){1'b0}}};
	localparam int PAD_W = M_TDATA_W - OUT_BITS;

	// Request fields.
	logic [OP_W-1:0]     req_op;
	logic [KEY_BITS-1:0] req_key;
	logic [CNT_W-1:0]    req_amt;

	assign req_op  = s_tdata[0 +: OP_W];
	assign req_key = s_tdata[OP_W +: KEY_BITS];
	assign req_amt = s_tdata[OP_W + KEY_BITS +: CNT_W];

	mct_state_t state_q, state_d;

	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    amt_q;
	logic [IDX_W-1:0]    idx_q;

	// Memory read stage.
	logic                chk_s1;
	logic                chk_vld_s1;
	logic [IDX_W-1:0]    chk_idx_s1;
	logic [KEY_BITS-1:0] rd_key_s1;
	logic [CNT_W-1:0]    rd_cnt_s1;

	// Scan results.
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [ENTRIES-1:0] valid_q;
	logic [DST_W-1:0]   distinct_q;
	logic [CNT_W-1:0]   sum_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [KEY_BITS-1:0] key_mem [ENTRIES];
	logic [CNT_W-1:0]    cnt_mem [ENTRIES];

	// Commit-stage decisions.
	logic                accept;
	logic                out_free;
	logic                commit;
	logic                ign;
	logic [CNT_W-1:0]    room;
	logic [CNT_W-1:0]    add_amt;
	logic [CNT_W-1:0]    sum_room;
	logic [CNT_W-1:0]    sum_add;
	logic [CNT_W-1:0]    sum_inc;
	logic [CNT_W-1:0]    rem;
	logic [CNT_W-1:0]    sum_dec;
	logic [STAT_W-1:0]   res_status;
	logic [CNT_W-1:0]    res_kc;
	logic [DST_W-1:0]    res_distinct;
	logic [CNT_W-1:0]    res_sum;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [CNT_W-1:0]    wr_cnt;
	logic                set_valid;
	logic                clr_valid;

	assign s_tready = (state_q == SM_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == SM_UPDATE) && out_free;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SM_IDLE: begin
				if (accept) begin
					state_d = SM_SCAN;
				end
			end
			SM_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = SM_DRAIN;
				end
			end
			SM_DRAIN: begin
				state_d = SM_UPDATE;
			end
			SM_UPDATE: begin
				if (out_free) begin
					state_d = SM_IDLE;
				end
			end
			default: begin
				state_d = SM_IDLE;
			end
		endcase
	end

	// Request capture and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			chk_s1     <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
		end else begin
			chk_s1 <= (state_q == SM_SCAN);
			if (accept) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			if (state_q == SM_SCAN) begin
				idx_q <= idx_q + 1'b1;
				if (!free_q && !valid_q[idx_q]) begin
					free_q <= 1'b1;
				end
			end
			// The compare runs in the cycle after the memory read is addressed.
			if (chk_s1 && chk_vld_s1 && !hit_q && (rd_key_s1 == key_q)) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req_op;
			key_q <= req_key;
			amt_q <= req_amt;
		end
		chk_idx_s1 <= idx_q;
		chk_vld_s1 <= valid_q[idx_q];
		if ((state_q == SM_SCAN) && !free_q && !valid_q[idx_q]) begin
			free_idx_q <= idx_q;
		end
		if (chk_s1 && chk_vld_s1 && !hit_q && (rd_key_s1 == key_q)) begin
			hit_idx_q <= chk_idx_s1;
			hit_cnt_q <= rd_cnt_s1;
		end
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (commit && wr_en) begin
			cnt_mem[wr_idx] <= wr_cnt;
			if (set_valid) begin
				key_mem[wr_idx] <= key_q;
			end
		end
		rd_key_s1 <= key_mem[idx_q];
		rd_cnt_s1 <= cnt_mem[idx_q];
	end

	always_comb begin
		ign      = (key_q == KEY_RESERVED) || (amt_q == '0);
		room     = CNT_MAX - hit_cnt_q;
		add_amt  = (amt_q > room) ? room : amt_q;
		sum_room = CNT_MAX - sum_q;
		sum_add  = hit_q ? add_amt : amt_q;
		sum_inc  = (sum_add > sum_room) ? CNT_MAX : (sum_q + sum_add);
		rem      = (amt_q >= hit_cnt_q) ? hit_cnt_q : amt_q;
		sum_dec  = (sum_q >= rem) ? (sum_q - rem) : '0;

		res_status   = STAT_DONE;
		res_kc       = hit_q ? hit_cnt_q : '0;
		res_distinct = distinct_q;
		res_sum      = sum_q;
		wr_en        = 1'b0;
		wr_idx       = hit_idx_q;
		wr_cnt       = hit_cnt_q;
		set_valid    = 1'b0;
		clr_valid    = 1'b0;

		case (op_q)
			OP_INSERT: begin
				if (ign) begin
					res_status = STAT_IGNORED;
				end else if (hit_q) begin
					wr_en   = 1'b1;
					wr_cnt  = hit_cnt_q + add_amt;
					res_kc  = hit_cnt_q + add_amt;
					res_sum = sum_inc;
				end else if (!free_q) begin
					res_status = STAT_FULL;
				end else begin
					wr_en        = 1'b1;
					wr_idx       = free_idx_q;
					wr_cnt       = amt_q;
					set_valid    = 1'b1;
					res_kc       = amt_q;
					res_distinct = distinct_q + 1'b1;
					res_sum      = sum_inc;
				end
			end
			OP_DELETE: begin
				if (ign || !hit_q) begin
					res_status = STAT_IGNORED;
				end else if (rem == hit_cnt_q) begin
					// Every copy removed: the entry is freed.
					clr_valid    = 1'b1;
					res_kc       = '0;
					res_sum      = sum_dec;
					res_distinct = (distinct_q != '0) ? distinct_q - 1'b1 : distinct_q;
				end else begin
					wr_en   = 1'b1;
					wr_cnt  = hit_cnt_q - rem;
					res_kc  = hit_cnt_q - rem;
					res_sum = sum_dec;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			distinct_q <= '0;
			sum_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (commit) begin
				m_tvalid_q <= 1'b1;
				distinct_q <= res_distinct;
				sum_q      <= res_sum;
				if (set_valid) begin
					valid_q[wr_idx] <= 1'b1;
				end else if (clr_valid) begin
					valid_q[wr_idx] <= 1'b0;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {{PAD_W{1'b0}}, res_sum, DIST_W'(res_distinct), res_kc, res_status};
		end
	end

endmodule

// ===== hw/rtl/mct_checker.sv =====
// Port-level checker for the multiset counting table core, bound to it below.
// Depends on mct_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module mct_checker #(
	parameter int ENTRIES = mct_pkg::ENTRIES_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mct_pkg::M_TDATA_W-1:0] m_tdata
);
	import mct_pkg::*;

	logic [STAT_W-1:0] out_status;
	logic [CNT_W-1:0]  out_kc;
	logic [DIST_W-1:0] out_dist;
	logic              dist_ok;

	assign out_status = m_tdata[OUT_ST_MSB:OUT_ST_LSB];
	assign out_kc     = m_tdata[OUT_KC_MSB:OUT_KC_LSB];
	assign out_dist   = m_tdata[OUT_DK_MSB:OUT_DK_LSB];
	// The reported count is only the low bits once the table exceeds its range.
	assign dist_ok    = (ENTRIES >= (1 << DIST_W)) || (int'(out_dist) <= ENTRIES);

	`MCT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	`MCT_ASSERT(a_one_request, s_tvalid && s_tready |=> !s_tready, "second request taken during a scan")
	`MCT_ASSERT(a_status_code, m_tvalid |-> (out_status == STAT_DONE) || (out_status == STAT_IGNORED) || (out_status == STAT_FULL), "status outside the defined codes")
	`MCT_ASSERT(a_full_bounds, m_tvalid |-> dist_ok && ((out_status != STAT_FULL) || (out_kc == '0)), "distinct count or full result out of range")
	`MCT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result shown during reset")

endmodule

bind multiset_count_table_core mct_checker #(.ENTRIES(ENTRIES)) u_mct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for multiset_count_table_core: random and directed requests
// are checked against a predictor of the key table kept in a small scoreboard class.
// Depends on mct_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
	import mct_pkg::*;

	localparam int ENTRIES = ENTRIES_DEF;
	localparam int KEY_W   = KEY_BITS_DEF;
	localparam int REQ_W   = ((OP_W + KEY_W + CNT_W + 7) / 8) * 8;
	localparam int REQ_KEY_LSB = OP_W;
	localparam int REQ_AMT_LSB = OP_W + KEY_W;
	localparam int WATCHDOG    = 3000;
	localparam int PRINT_CAP   = 100;

	// Opcode 3 is not named by the package; the block handles it as a query.
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam logic [KEY_W-1:0] KEY_RESERVED = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic [KEY_W-1:0] KEY_TOP      = {1'b0, {(KEY_W-1){1'b1}}};
	localparam logic [KEY_W-1:0] KEY_BOTTOM   = {1'b1, {(KEY_W-2){1'b0}}, 1'b1};

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  key_count;
		logic [DIST_W-1:0] distinct_keys;
		logic [CNT_W-1:0]  total_count;
	} count_reply_t;

	class count_table_board;
		logic [KEY_W-1:0] key_tab [ENTRIES];
		logic [CNT_W-1:0] cnt_tab [ENTRIES];
		bit               used [ENTRIES];
		int               n_keys;
		logic [CNT_W-1:0] total;
		count_reply_t     replies_due [$];
		int               fails;

		function new();
			foreach (used[i]) used[i] = 1'b0;
			n_keys = 0;
			total  = '0;
			fails  = 0;
		endfunction

		function logic [CNT_W-1:0] sat_sum(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
			logic [CNT_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
		endfunction

		// Updates the table copy for one accepted request and queues its reply.
		function void apply_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
				logic [CNT_W-1:0] amt);
			count_reply_t r;
			int idx;
			int slot;
			logic [CNT_W-1:0] c;
			logic [CNT_W-1:0] nc;
			logic [CNT_W-1:0] rem;
			r.status = STAT_DONE;
			r.key_count = '0;
			idx = -1;
			slot = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (used[i] && key_tab[i] == k && idx < 0) idx = i;
				if (!used[i] && slot < 0) slot = i;
			end
			if (op == OP_INSERT) begin
				if (k == KEY_RESERVED || amt == '0) begin
					r.status = STAT_IGNORED;
					r.key_count = (idx >= 0) ? cnt_tab[idx] : '0;
				end else if (idx >= 0) begin
					c = cnt_tab[idx];
					nc = sat_sum(c, amt);
					total = sat_sum(total, nc - c);
					cnt_tab[idx] = nc;
					r.key_count = nc;
				end else if (slot < 0) begin
					r.status = STAT_FULL;
				end else begin
					used[slot] = 1'b1;
					key_tab[slot] = k;
					cnt_tab[slot] = amt;
					n_keys++;
					total = sat_sum(total, amt);
					r.key_count = amt;
				end
			end else if (op == OP_DELETE) begin
				if (k == KEY_RESERVED || amt == '0 || idx < 0) begin
					r.status = STAT_IGNORED;
					r.key_count = (idx >= 0) ? cnt_tab[idx] : '0;
				end else begin
					c = cnt_tab[idx];
					rem = (amt >= c) ? c : amt;
					total = (total >= rem) ? total - rem : '0;
					if (rem == c) begin
						used[idx] = 1'b0;
						cnt_tab[idx] = '0;
						if (n_keys > 0) n_keys--;
					end else begin
						cnt_tab[idx] = c - rem;
						r.key_count = c - rem;
					end
				end
			end else begin
				r.key_count = (idx >= 0) ? cnt_tab[idx] : '0;
			end
			r.distinct_keys = n_keys[DIST_W-1:0];
			r.total_count = total;
			replies_due.push_back(r);
		endfunction

		task report_mismatch(string msg);
			fails++;
			if (fails <= PRINT_CAP) $display("tb: mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_reply(logic [M_TDATA_W-1:0] d);
			count_reply_t want;
			if (replies_due.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			want = replies_due.pop_front();
			if (d[OUT_ST_MSB:OUT_ST_LSB] !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d",
					d[OUT_ST_MSB:OUT_ST_LSB], want.status));
			if (d[OUT_KC_MSB:OUT_KC_LSB] !== want.key_count)
				report_mismatch($sformatf("key_count %0d, expected %0d",
					d[OUT_KC_MSB:OUT_KC_LSB], want.key_count));
			if (d[OUT_DK_MSB:OUT_DK_LSB] !== want.distinct_keys)
				report_mismatch($sformatf("distinct_keys %0d, expected %0d",
					d[OUT_DK_MSB:OUT_DK_LSB], want.distinct_keys));
			if (d[OUT_TC_MSB:OUT_TC_LSB] !== want.total_count)
				report_mismatch($sformatf("total_count %0d, expected %0d",
					d[OUT_TC_MSB:OUT_TC_LSB], want.total_count));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [REQ_W-1:0]       s_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;

	count_table_board board = new();
	logic [KEY_W-1:0] key_pool [$];
	int tx_idle_pct;
	int rx_stall_pct;
	int quiet_cycles = 0;

	multiset_count_table_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= rx_stall_pct);
	end

	// Results are checked and progress is watched at every rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_reply(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [CNT_W-1:0] amt);
		logic [REQ_W-1:0] word;
		word = '0;
		word[OP_W-1:0] = op;
		word[REQ_KEY_LSB +: KEY_W] = k;
		word[REQ_AMT_LSB +: CNT_W] = amt;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		board.apply_request(op, k, amt);
		@(negedge clk);
	endtask

	task automatic random_request();
		int pick;
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] k;
		logic [CNT_W-1:0] amt;
		pick = $urandom_range(99);
		if (pick < 45) op = OP_INSERT;
		else if (pick < 75) op = OP_DELETE;
		else if (pick < 95) op = OP_QUERY;
		else op = OP_SPARE;
		pick = $urandom_range(99);
		if (pick < 85) begin
			k = key_pool[$urandom_range(key_pool.size() - 1)];
		end else if (pick < 95) begin
			k = $urandom;
		end else begin
			case ($urandom_range(4))
				0: k = KEY_RESERVED;
				1: k = KEY_TOP;
				2: k = KEY_BOTTOM;
				3: k = '0;
				default: k = '1;
			endcase
		end
		pick = $urandom_range(99);
		if (pick < 5) amt = '0;
		else if (pick < 30) amt = CNT_W'($urandom);
		else amt = CNT_W'($urandom_range(16, 1));
		send_request(op, k, amt);
	endtask

	initial begin
		logic [KEY_W-1:0] k;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table, ignored requests, both saturations and the total floor.
		send_request(OP_QUERY, '0, 31'd0);
		send_request(OP_INSERT, KEY_RESERVED, 31'd5);
		send_request(OP_INSERT, '0, 31'd0);
		send_request(OP_DELETE, 32'd7, 31'd1);
		send_request(OP_INSERT, KEY_TOP, 31'd1);
		send_request(OP_INSERT, KEY_BOTTOM, CNT_MAX);
		send_request(OP_INSERT, KEY_TOP, CNT_MAX);
		send_request(OP_QUERY, KEY_RESERVED, CNT_MAX);
		send_request(OP_DELETE, KEY_RESERVED, 31'd1);
		send_request(OP_DELETE, KEY_TOP, 31'd0);
		send_request(OP_DELETE, KEY_BOTTOM, 31'd5);
		send_request(OP_DELETE, KEY_TOP, CNT_MAX);
		send_request(OP_SPARE, KEY_BOTTOM, 31'd9);
		send_request(OP_INSERT, '1, 31'd1);
		send_request(OP_INSERT, '1, 31'd2);
		send_request(OP_DELETE, '1, 31'd10);
		send_request(OP_QUERY, '1, 31'd0);
		send_request(OP_DELETE, KEY_BOTTOM, CNT_MAX);
		send_request(OP_INSERT, '0, 31'd12345);
		send_request(OP_QUERY, '0, 31'd0);
		send_request(OP_INSERT, 32'h5555_5555, 31'h2AAA_AAAA);
		send_request(OP_INSERT, 32'hAAAA_AAAA, 31'h5555_5555);
		key_pool.push_back('0);
		key_pool.push_back(32'h5555_5555);
		key_pool.push_back(32'hAAAA_AAAA);
		key_pool.push_back(KEY_TOP);

		// Fill every entry, then offer new keys to a full table.
		while (board.n_keys < ENTRIES) begin
			k = $urandom;
			if (k != KEY_RESERVED) begin
				key_pool.push_back(k);
				send_request(OP_INSERT, k, CNT_W'($urandom_range(40, 1)));
			end
		end
		repeat (4) begin
			k = $urandom;
			key_pool.push_back(k);
			send_request(OP_INSERT, k, CNT_W'($urandom_range(40, 1)));
		end

		repeat (90) random_request();
		tx_idle_pct = 58;
		repeat (150) random_request();
		tx_idle_pct = 0;
		rx_stall_pct = 58;
		repeat (150) random_request();
		tx_idle_pct = 34;
		rx_stall_pct = 34;
		repeat (150) random_request();
		s_tvalid <= 1'b0;

		while (board.replies_due.size() != 0) @(posedge clk);
		repeat (ENTRIES + 16) @(posedge clk);
		if (board.replies_due.size() != 0)
			board.report_mismatch("results still outstanding at the end");
		if (board.fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
